// ===== rtl/core/vfv_pkg.sv =====
// Shared types and constants for the voxel face visibility block.
`timescale 1ns / 1ps
`default_nettype none

package vfv_pkg;

    localparam int COORD_BITS = 6;
    localparam int ROW_BITS   = 2 * COORD_BITS;
    localparam int WORD_BITS  = 1 << COORD_BITS;
    localparam int ROWS       = 1 << ROW_BITS;

    localparam int CHUNK_SIDE_DEF = 16;
    localparam int MAX_CHUNKS_DEF = 4;

    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int FACE_W    = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_Z = 2'd2;

    localparam logic [CFG_W-1:0] CHUNKS_RESET = 3'd4;

    localparam logic MODE_SET   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET_RD,
        ST_SET_WR,
        ST_Q_C,
        ST_Q_YM,
        ST_Q_YP,
        ST_Q_XM,
        ST_Q_XP,
        ST_Q_DONE
    } state_t;

    typedef enum logic [2:0] {
        ROW_C,
        ROW_YM,
        ROW_YP,
        ROW_XM,
        ROW_XP
    } row_sel_t;

    typedef struct packed {
        logic     clear_step;
        logic     capture;
        logic     rd_en;
        row_sel_t row_sel;
        logic     set_wr;
        logic     cap_centre;
        logic     cap_ym;
        logic     cap_yp;
        logic     cap_xm;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_blocked;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/vfv_ctrl.sv =====
// Sequencer for clearing, set and query transactions.
`timescale 1ns / 1ps
`default_nettype none

module vfv_ctrl
    import vfv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    mode,
    output logic         in_stall,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (mode == MODE_QUERY) ? ST_Q_C : ST_SET_RD;
                end
            end
            ST_SET_RD: state_next = ST_SET_WR;
            ST_SET_WR: state_next = ST_IDLE;
            ST_Q_C:    state_next = ST_Q_YM;
            ST_Q_YM:   state_next = ST_Q_YP;
            ST_Q_YP:   state_next = ST_Q_XM;
            ST_Q_XM:   state_next = ST_Q_XP;
            ST_Q_XP:   state_next = ST_Q_DONE;
            ST_Q_DONE:
            begin
                if (!status.out_blocked)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.row_sel = ROW_C;
        in_stall = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_SET_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.row_sel = ROW_C;
            end
            ST_SET_WR:
            begin
                cmd.set_wr  = 1'b1;
                cmd.row_sel = ROW_C;
            end
            ST_Q_C:
            begin
                cmd.rd_en   = 1'b1;
                cmd.row_sel = ROW_C;
            end
            ST_Q_YM:
            begin
                cmd.rd_en      = 1'b1;
                cmd.row_sel    = ROW_YM;
                cmd.cap_centre = 1'b1;
            end
            ST_Q_YP:
            begin
                cmd.rd_en   = 1'b1;
                cmd.row_sel = ROW_YP;
                cmd.cap_ym  = 1'b1;
            end
            ST_Q_XM:
            begin
                cmd.rd_en   = 1'b1;
                cmd.row_sel = ROW_XM;
                cmd.cap_yp  = 1'b1;
            end
            ST_Q_XP:
            begin
                cmd.rd_en   = 1'b1;
                cmd.row_sel = ROW_XP;
                cmd.cap_xm  = 1'b1;
            end
            ST_Q_DONE:
            begin
                cmd.out_load = !status.out_blocked;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/vfv_datapath.sv =====
// Occupancy memory, grid bounds, neighbour capture and result register.
`timescale 1ns / 1ps
`default_nettype none

module vfv_datapath
    import vfv_pkg::*;
#(
    parameter int CHUNK_SIDE = CHUNK_SIDE_DEF,
    parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    input  wire logic                  mode,
    input  wire logic [COORD_BITS-1:0] x_coord,
    input  wire logic [COORD_BITS-1:0] y_coord,
    input  wire logic [COORD_BITS-1:0] z_coord,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       occupied,
    output logic [FACE_W-1:0]          exposed_faces
);

    localparam int LIM_W = $clog2(MAX_CHUNKS * CHUNK_SIDE + 1);
    localparam int CMP_W = (LIM_W > COORD_BITS + 1) ? LIM_W : COORD_BITS + 1;

    // row = {x, y}; z picks the bit within the row
    logic [WORD_BITS-1:0] occ_mem [ROWS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [ROW_BITS-1:0]  clr_cnt_reg;

    logic [CFG_W-1:0] chunks_x_reg;
    logic [CFG_W-1:0] chunks_y_reg;
    logic [CFG_W-1:0] chunks_z_reg;

    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic [COORD_BITS-1:0] z_reg;
    logic                  mode_reg;

    logic centre_reg;
    logic zm_reg;
    logic zp_reg;
    logic ym_reg;
    logic yp_reg;
    logic xm_reg;

    logic              out_valid_reg;
    logic              occupied_reg;
    logic [FACE_W-1:0] faces_reg;

    function automatic logic [CMP_W-1:0] axis_limit(input logic [CFG_W-1:0] chunks);
        logic [CMP_W-1:0] n;
        n = CMP_W'(chunks);
        if (chunks == '0)
        begin
            n = CMP_W'(1);
        end
        if (n > CMP_W'(MAX_CHUNKS))
        begin
            n = CMP_W'(MAX_CHUNKS);
        end
        return CMP_W'(n * CMP_W'(CHUNK_SIDE));
    endfunction

    logic [CMP_W-1:0] lim_x;
    logic [CMP_W-1:0] lim_y;
    logic [CMP_W-1:0] lim_z;

    assign lim_x = axis_limit(chunks_x_reg);
    assign lim_y = axis_limit(chunks_y_reg);
    assign lim_z = axis_limit(chunks_z_reg);

    logic [COORD_BITS-1:0] x_m1, x_p1, y_m1, y_p1, z_m1, z_p1;
    logic [COORD_BITS:0]   x_up, y_up, z_up;

    assign x_m1 = x_reg - COORD_BITS'(1);
    assign y_m1 = y_reg - COORD_BITS'(1);
    assign z_m1 = z_reg - COORD_BITS'(1);
    assign x_up = {1'b0, x_reg} + (COORD_BITS + 1)'(1);
    assign y_up = {1'b0, y_reg} + (COORD_BITS + 1)'(1);
    assign z_up = {1'b0, z_reg} + (COORD_BITS + 1)'(1);
    assign x_p1 = x_up[COORD_BITS-1:0];
    assign y_p1 = y_up[COORD_BITS-1:0];
    assign z_p1 = z_up[COORD_BITS-1:0];

    // per-axis bound checks for the voxel itself and one step either way
    logic in_x, in_xm, in_xp, in_y, in_ym, in_yp, in_z, in_zm, in_zp;

    assign in_x  = CMP_W'(x_reg) < lim_x;
    assign in_y  = CMP_W'(y_reg) < lim_y;
    assign in_z  = CMP_W'(z_reg) < lim_z;
    assign in_xm = (x_reg != '0) && (CMP_W'(x_m1) < lim_x);
    assign in_ym = (y_reg != '0) && (CMP_W'(y_m1) < lim_y);
    assign in_zm = (z_reg != '0) && (CMP_W'(z_m1) < lim_z);
    assign in_xp = !x_up[COORD_BITS] && (CMP_W'(x_up) < lim_x);
    assign in_yp = !y_up[COORD_BITS] && (CMP_W'(y_up) < lim_y);
    assign in_zp = !z_up[COORD_BITS] && (CMP_W'(z_up) < lim_z);

    logic bit_z;
    assign bit_z = rd_data_reg[z_reg];

    logic [ROW_BITS-1:0] row_addr;

    always_comb
    begin
        case (cmd.row_sel)
            ROW_C:   row_addr = {x_reg, y_reg};
            ROW_YM:  row_addr = {x_reg, y_m1};
            ROW_YP:  row_addr = {x_reg, y_p1};
            ROW_XM:  row_addr = {x_m1, y_reg};
            ROW_XP:  row_addr = {x_p1, y_reg};
            default: row_addr = {x_reg, y_reg};
        endcase
    end

    logic [ROW_BITS-1:0]  mem_addr;
    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] set_mask;

    assign set_mask  = WORD_BITS'(1) << z_reg;
    assign mem_addr  = cmd.clear_step ? clr_cnt_reg : row_addr;
    assign mem_we    = cmd.clear_step || (cmd.set_wr && in_x && in_y && in_z);
    assign mem_wdata = cmd.clear_step ? '0 : (rd_data_reg | set_mask);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            occ_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= occ_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + ROW_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunks_x_reg <= CHUNKS_RESET;
            chunks_y_reg <= CHUNKS_RESET;
            chunks_z_reg <= CHUNKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHUNKS_X: chunks_x_reg <= cfg_data;
                CFG_CHUNKS_Y: chunks_y_reg <= cfg_data;
                CFG_CHUNKS_Z: chunks_z_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            x_reg    <= x_coord;
            y_reg    <= y_coord;
            z_reg    <= z_coord;
        end
        if (cmd.cap_centre)
        begin
            centre_reg <= in_x && in_y && in_z && bit_z;
            zm_reg     <= in_x && in_y && in_zm && rd_data_reg[z_m1];
            zp_reg     <= in_x && in_y && in_zp && rd_data_reg[z_p1];
        end
        if (cmd.cap_ym)
        begin
            ym_reg <= in_x && in_ym && in_z && bit_z;
        end
        if (cmd.cap_yp)
        begin
            yp_reg <= in_x && in_yp && in_z && bit_z;
        end
        if (cmd.cap_xm)
        begin
            xm_reg <= in_xm && in_y && in_z && bit_z;
        end
    end

    logic              xp_bit;
    logic [FACE_W-1:0] neigh;

    assign xp_bit = in_xp && in_y && in_z && bit_z;
    assign neigh  = {xp_bit, xm_reg, yp_reg, ym_reg, zp_reg, zm_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            occupied_reg <= centre_reg;
            faces_reg    <= centre_reg ? ~neigh : '0;
        end
    end

    // mode is held for the active transaction; a non-query mode keeps out_blocked set
    logic query_active;
    assign query_active = (mode_reg == MODE_QUERY);

    assign status.clear_last  = (clr_cnt_reg == ROW_BITS'(ROWS - 1));
    assign status.out_blocked = (out_valid_reg && out_stall) || !query_active;

    assign out_valid     = out_valid_reg;
    assign occupied      = occupied_reg;
    assign exposed_faces = faces_reg;

endmodule

`default_nettype wire

// ===== rtl/core/voxel_face_visibility.sv =====
// Top level of the voxel occupancy grid with face visibility queries.
// Set transaction: a row read (SET_RD) then a write (SET_WR), then the next item is accepted.
// Query transaction: the result is loaded in Q_DONE after the row reads of Q_C to Q_XP;
//   the steps come from five row reads through the single-port occupancy memory.
// The result register lets the next item enter while a result waits to be taken.
// After reset a clearing pass writes all 4096 memory rows, one a cycle, with
// in_stall high; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module voxel_face_visibility
    import vfv_pkg::*;
#(
    parameter int CHUNK_SIDE = CHUNK_SIDE_DEF,
    parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  mode,
    input  wire logic [COORD_BITS-1:0] x_coord,
    input  wire logic [COORD_BITS-1:0] y_coord,
    input  wire logic [COORD_BITS-1:0] z_coord,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       occupied,
    output logic [FACE_W-1:0]          exposed_faces,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    cmd_t    cmd;
    status_t status;

    vfv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    vfv_datapath #(
        .CHUNK_SIDE (CHUNK_SIDE),
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .mode          (mode),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .z_coord       (z_coord),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .occupied      (occupied),
        .exposed_faces (exposed_faces)
    );

endmodule

`default_nettype wire
